[src/rlsd_pkg.sv]
package rlsd_pkg;

    // Panel geometry. Both dimensions are powers of two.
    localparam int PANEL_WIDTH  = 64;
    localparam int PANEL_HEIGHT = 32;

    localparam int SCAN_ROWS = PANEL_HEIGHT / 2;
    localparam int COL_W     = $clog2(PANEL_WIDTH);
    localparam int ROW_W     = $clog2(PANEL_HEIGHT);
    localparam int SROW_W    = $clog2(SCAN_ROWS);
    localparam int CELL_W    = COL_W + ROW_W;   // pixel index within one frame
    localparam int ADDR_W    = CELL_W + 1;      // frame select on top
    localparam int MEM_DEPTH = 2 * PANEL_WIDTH * PANEL_HEIGHT;

    localparam logic [7:0] X_LIMIT = 8'(PANEL_WIDTH);
    localparam logic [6:0] Y_LIMIT = 7'(PANEL_HEIGHT);

    // Action codes of an input item, also used as command kinds in the queue.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [15:0] ON_TIME_RESET = 16'd50;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CELL_W-1:0] pix_idx;
        logic [2:0]        color;
    } t_cmd;

    typedef struct packed {
        logic [3:0] row_addr;
        logic [2:0] upper_rgb;
        logic [2:0] lower_rgb;
        logic       shift_clock;
        logic       latch_pulse;
        logic       output_enable;
        logic       frame_done;
    } t_res;

endpackage

[src/rlsd_if.sv]
interface rlsd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [2:0] color;

    modport source (output valid, action, pos_x, pos_y, color, input ready);
    modport sink   (input valid, action, pos_x, pos_y, color, output ready);
endinterface

interface rlsd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_addr;
    logic [2:0] upper_rgb;
    logic [2:0] lower_rgb;
    logic       shift_clock;
    logic       latch_pulse;
    logic       output_enable;
    logic       frame_done;

    modport source (output valid, row_addr, upper_rgb, lower_rgb, shift_clock,
                     latch_pulse, output_enable, frame_done, input ready);
    modport sink   (input valid, row_addr, upper_rgb, lower_rgb, shift_clock,
                    latch_pulse, output_enable, frame_done, output ready);
endinterface

[src/rlsd_front.sv]
module rlsd_front (
    rlsd_in_if.sink        i_pix,
    input  logic           i_init_busy,
    input  logic           i_q_full,
    output logic           o_push,
    output rlsd_pkg::t_cmd o_cmd
);
    import rlsd_pkg::*;

    logic x_ok;
    logic y_ok;
    logic keep;

    assign x_ok = (i_pix.pos_x != 7'd0) && ({1'b0, i_pix.pos_x} <= X_LIMIT);
    assign y_ok = (i_pix.pos_y != 6'd0) && ({1'b0, i_pix.pos_y} <= Y_LIMIT);

    // Off-panel writes and the unused code are dropped here.
    always_comb begin
        unique case (i_pix.action)
            ACT_WRITE: keep = x_ok && y_ok;
            ACT_CLEAR: keep = 1'b1;
            ACT_TICK:  keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign i_pix.ready = !i_q_full && !i_init_busy;
    assign o_push      = i_pix.valid && i_pix.ready && keep;

    assign o_cmd.kind    = i_pix.action;
    assign o_cmd.pix_idx = {ROW_W'(i_pix.pos_y - 6'd1), COL_W'(i_pix.pos_x - 7'd1)};
    assign o_cmd.color   = i_pix.color;

endmodule

[src/rlsd_queue.sv]
module rlsd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rlsd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output rlsd_pkg::t_cmd o_cmd
);
    import rlsd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[src/rlsd_back.sv]
module rlsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_wdata,
    input  logic           i_q_valid,
    input  rlsd_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_init_busy,
    rlsd_out_if.source     o_scan
);
    import rlsd_pkg::*;

    localparam logic [1:0] PH_SHIFT = 2'd0;
    localparam logic [1:0] PH_LATCH = 2'd1;
    localparam logic [1:0] PH_LIT   = 2'd2;

    localparam logic [COL_W-1:0]  COL_LAST = COL_W'(PANEL_WIDTH - 1);
    localparam logic [SROW_W-1:0] ROW_LAST = SROW_W'(SCAN_ROWS - 1);

    // config
    logic [15:0] r_on_time;

    // scan state
    logic [1:0]        r_phase, n_phase;
    logic [COL_W-1:0]  r_col, n_col;
    logic [SROW_W-1:0] r_row, n_row;
    logic [15:0]       r_lit, n_lit;
    logic              r_front, n_front;
    logic [15:0]       lit_inc;
    t_res              tick_res;

    // sweep (reset fill and back-frame clear)
    logic              r_sweep_active;
    logic              r_sweep_full;
    logic [ADDR_W-1:0] r_sweep_cnt;
    logic              sweep_last;

    // frame store
    logic [2:0]        r_mem [MEM_DEPTH];
    logic [2:0]        r_up_rgb;
    logic [2:0]        r_lo_rgb;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [2:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] addr_up;
    logic [ADDR_W-1:0] addr_lo;

    // issue / read / output stages
    logic is_tick;
    logic issue_tick;
    logic rd_adv;
    logic r_rd_valid;
    t_res r_rd_res;
    logic r_out_valid;
    t_res r_out;

    assign o_init_busy = r_sweep_active && r_sweep_full;

    assign rd_adv     = r_rd_valid && (!r_out_valid || o_scan.ready);
    assign is_tick    = (i_q_cmd.kind == ACT_TICK);
    assign o_q_pop    = !r_sweep_active && i_q_valid && (!is_tick || !r_rd_valid || rd_adv);
    assign issue_tick = o_q_pop && is_tick;

    assign sweep_last = r_sweep_full ? (r_sweep_cnt == '1)
                                     : (r_sweep_cnt[CELL_W-1:0] == '1);

    // scan sequencer next state
    assign lit_inc = r_lit + 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_col    = r_col;
        n_row    = r_row;
        n_lit    = r_lit;
        n_front  = r_front;
        tick_res = '0;
        tick_res.row_addr = 4'(r_row);
        unique case (r_phase)
            PH_LATCH: begin
                tick_res.latch_pulse = 1'b1;
                n_phase = PH_LIT;
                n_lit   = 16'd0;
            end
            PH_LIT: begin
                tick_res.output_enable = 1'b1;
                n_lit = lit_inc;
                if ((lit_inc >= r_on_time) || (lit_inc == 16'd0)) begin
                    n_lit   = 16'd0;
                    n_phase = PH_SHIFT;
                    n_col   = '0;
                    if (r_row == ROW_LAST) begin
                        n_row   = '0;
                        n_front = !r_front;
                        tick_res.frame_done = 1'b1;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            PH_SHIFT: begin
                tick_res.shift_clock = 1'b1;
                if (r_col == COL_LAST) begin
                    n_col   = '0;
                    n_phase = PH_LATCH;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            default: begin
                n_phase = PH_SHIFT;
            end
        endcase
    end

    // memory ports
    assign mem_we    = r_sweep_active || (o_q_pop && (i_q_cmd.kind == ACT_WRITE));
    assign mem_waddr = r_sweep_active
                     ? (r_sweep_full ? r_sweep_cnt : {!r_front, r_sweep_cnt[CELL_W-1:0]})
                     : {!r_front, i_q_cmd.pix_idx};
    assign mem_wdata = r_sweep_active ? 3'd0 : i_q_cmd.color;
    assign mem_re    = issue_tick && (r_phase == PH_SHIFT);
    assign addr_up   = {r_front, 1'b0, r_row, r_col};
    assign addr_lo   = {r_front, 1'b1, r_row, r_col};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_up_rgb <= r_mem[addr_up];
            r_lo_rgb <= r_mem[addr_lo];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time      <= ON_TIME_RESET;
            r_phase        <= PH_SHIFT;
            r_col          <= '0;
            r_row          <= '0;
            r_lit          <= 16'd0;
            r_front        <= 1'b0;
            r_sweep_active <= 1'b1;
            r_sweep_full   <= 1'b1;
            r_sweep_cnt    <= '0;
            r_rd_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_on_time <= i_cfg_wdata;
            end
            if (issue_tick) begin
                r_phase <= n_phase;
                r_col   <= n_col;
                r_row   <= n_row;
                r_lit   <= n_lit;
                r_front <= n_front;
            end
            if (r_sweep_active) begin
                r_sweep_cnt <= r_sweep_cnt + 1'b1;
                if (sweep_last) begin
                    r_sweep_active <= 1'b0;
                end
            end else if (o_q_pop && (i_q_cmd.kind == ACT_CLEAR)) begin
                r_sweep_active <= 1'b1;
                r_sweep_full   <= 1'b0;
                r_sweep_cnt    <= '0;
            end
            if (issue_tick) begin
                r_rd_valid <= 1'b1;
            end else if (rd_adv) begin
                r_rd_valid <= 1'b0;
            end
            if (rd_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_scan.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (issue_tick) begin
            r_rd_res <= tick_res;
        end
        if (rd_adv) begin
            r_out <= r_rd_res;
            if (r_rd_res.shift_clock) begin
                r_out.upper_rgb <= r_up_rgb;
                r_out.lower_rgb <= r_lo_rgb;
            end
        end
    end

    assign o_scan.valid         = r_out_valid;
    assign o_scan.row_addr      = r_out.row_addr;
    assign o_scan.upper_rgb     = r_out.upper_rgb;
    assign o_scan.lower_rgb     = r_out.lower_rgb;
    assign o_scan.shift_clock   = r_out.shift_clock;
    assign o_scan.latch_pulse   = r_out.latch_pulse;
    assign o_scan.output_enable = r_out.output_enable;
    assign o_scan.frame_done    = r_out.frame_done;

endmodule

[src/rgb_led_matrix_scan_driver.sv]
// Double-buffered scan driver for a 64x32, 1/16-scan RGB LED panel.
//
// i_pix (valid/ready): one item per handshake. action selects pixel write
//   (pos_x, pos_y 1-based, color), clear of the back frame, or scan tick.
//   Off-panel writes and the unused action code give no result.
// o_scan (valid/ready): one pin-state item per scan tick, in order.
// i_cfg_we / i_cfg_wdata: on_time_ticks, lit ticks per row (0 acts as 1).
//
// A scan tick passes through the queue, the frame-store read stage and the
// output register before it shows on o_scan. Throughput is one item per
// cycle when no sweep or o_scan stall holds it, set by the single-issue
// back end and its one write port. A clear holds the back end while it
// sweeps the back frame; the 2-entry queue takes items until it fills.
// Reset: i_rst_n (synchronous) zeroes the scan state, selects frame 0 and
// starts a pass that zeroes the whole frame store; i_pix.ready stays low
// for that pass. Config writes are taken whenever i_rst_n is high.
// A stall on o_scan holds the result in the output register; one more
// result waits in the read stage, then the queue and i_pix back up.
module rgb_led_matrix_scan_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    rlsd_in_if.sink     i_pix,
    rlsd_out_if.source  o_scan
);
    import rlsd_pkg::*;

    logic init_busy;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    t_cmd push_cmd;
    t_cmd q_cmd;

    // front: handshake and classification
    rlsd_front u_front (
        .i_pix       (i_pix),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decoupling queue
    rlsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    // back: frame store, scan sequencer, result output
    rlsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_scan      (o_scan)
    );

endmodule

[src/rlsd_checker.sv]
module rlsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_row_addr,
    input logic [2:0] i_upper_rgb,
    input logic [2:0] i_lower_rgb,
    input logic       i_shift_clock,
    input logic       i_latch_pulse,
    input logic       i_output_enable,
    input logic       i_frame_done
);
    import rlsd_pkg::*;

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_row_addr)
            && $stable(i_frame_done) && $stable(i_upper_rgb))
        else $error("result changed under stall");

    // fill pass after reset: nothing in, nothing out
    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_in_ready && !i_out_valid)
        else $error("activity right after reset");

    // frame end only on a lit tick of the last row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> i_output_enable && !i_shift_clock
            && !i_latch_pulse && (i_row_addr == 4'(SCAN_ROWS - 1)))
        else $error("frame_done off the last lit tick");

    // colors only on shift ticks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_shift_clock |-> (i_upper_rgb == 3'd0) && (i_lower_rgb == 3'd0))
        else $error("color outside shift tick");

    // exactly one kind of tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot({i_shift_clock, i_latch_pulse, i_output_enable}))
        else $error("tick kind not unique");

endmodule

bind rgb_led_matrix_scan_driver rlsd_checker u_rlsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_scan.valid),
    .i_out_ready     (o_scan.ready),
    .i_row_addr      (o_scan.row_addr),
    .i_upper_rgb     (o_scan.upper_rgb),
    .i_lower_rgb     (o_scan.lower_rgb),
    .i_shift_clock   (o_scan.shift_clock),
    .i_latch_pulse   (o_scan.latch_pulse),
    .i_output_enable (o_scan.output_enable),
    .i_frame_done    (o_scan.frame_done)
);
